// ----- hdl/hlnc_pkg.sv -----
// Shared types and constants for the hashed LRU name cache.
`default_nettype none
package hlnc_pkg;
	localparam int ENTRIES     = 512;
	localparam int BUCKET_BITS = 7;
	localparam int NAME_BYTES  = 256;
	localparam int BUCKETS     = 1 << BUCKET_BITS;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PTR_W       = $clog2(ENTRIES + 1);
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int NB_W        = $clog2(NAME_BYTES);
	localparam int LEN_W       = $clog2(NAME_BYTES + 1);
	localparam int NBA_W       = $clog2(ENTRIES * NAME_BYTES);
	localparam int CLR_N       = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
	localparam int CLR_W       = $clog2(CLR_N);
	localparam logic [PTR_W-1:0] NONE = PTR_W'(ENTRIES);

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_INVAL  = 2'd2;
	localparam logic [1:0] KIND_BAD    = 2'd3;

	typedef enum logic [2:0] {
		ST_MISS        = 3'd0,
		ST_HIT         = 3'd1,
		ST_INSERTED    = 3'd2,
		ST_PRESENT     = 3'd3,
		ST_INVALIDATED = 3'd4,
		ST_REJECTED    = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        cacheable;
		logic [31:0] mount_id;
		logic [63:0] parent_inode;
		logic [7:0]  name_byte;
		logic        byte_valid;
		logic        name_last;
		logic [31:0] object_handle;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        ref_take;
		logic [31:0] ref_handle;
		logic        release_valid;
		logic [31:0] release_handle;
	} result_t;

	// Per-entry record kept in the entry memory.
	typedef struct packed {
		logic                   valid;
		logic [31:0]            mount;
		logic [63:0]            parent;
		logic [LEN_W-1:0]       len;
		logic [31:0]            obj;
		logic [BUCKET_BITS-1:0] bucket;
	} meta_t;

	// True when a link pointer holds the none marker.
	function automatic logic is_none(input logic [PTR_W-1:0] p);
		is_none = (p >= NONE);
	endfunction
endpackage
`default_nettype wire

// ----- hdl/hashed_lru_name_cache_unit.sv -----
// Top level of the hashed LRU name cache: name streaming, chain search and list updates.
//
// Name bytes are taken one per cycle; busy stays low between bytes. The item marked
// name_last starts the operation and holds busy high until its single result beat
// appears on result for one cycle with done high; the receiver cannot stall, so each
// result must be taken in that cycle (rejected requests answer in the next cycle
// without going busy). The sequencer reads the bucket head, then for each chain entry
// reads the key and, when mount, inode and length match, compares the name byte by
// byte; a miss ends at the end of the chain, then the result is decided. A found
// entry of a lookup or insert is moved to the recency head unless it is there already,
// an invalidate unlinks the entry and returns it to the spare list, and an insert takes
// a spare entry or evicts the recency tail, copies the name into the name store and
// links the entry at both heads. After reset a clearing pass initializes the entry,
// link and bucket head memories, during which busy is high.
`default_nettype none
module hashed_lru_name_cache_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire hlnc_pkg::item_t item,
	output logic                 done,
	output hlnc_pkg::result_t    result
);
	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_HEAD, S_HEAD_WT, S_ENT_RD, S_ENT_WT, S_BYTE_RD, S_BYTE_CK,
		S_FOUND, S_MISS, S_TU, S_F1, S_F2, S_DROP, S_SPARE, S_SPARE_WT, S_VICT_RD,
		S_VICT_WT, S_VICT_UNL, S_FILL, S_COPY, S_LINK_RD, S_LINK_WT, S_LINK2, S_DONE
	} state_t;

	localparam int IW = hlnc_pkg::IDX_W;
	localparam int PW = hlnc_pkg::PTR_W;

	// Memories.
	hlnc_pkg::meta_t meta_mem [hlnc_pkg::ENTRIES];
	logic [PW-1:0]   cn_mem   [hlnc_pkg::ENTRIES];
	logic [PW-1:0]   cp_mem   [hlnc_pkg::ENTRIES];
	logic [PW-1:0]   rn_mem   [hlnc_pkg::ENTRIES];
	logic [PW-1:0]   rp_mem   [hlnc_pkg::ENTRIES];
	logic [PW-1:0]   sn_mem   [hlnc_pkg::ENTRIES];
	logic [PW-1:0]   bh_mem   [hlnc_pkg::BUCKETS];
	logic [7:0]      nb_mem   [hlnc_pkg::ENTRIES * hlnc_pkg::NAME_BYTES];
	logic [7:0]      nbuf_mem [hlnc_pkg::NAME_BYTES];

	state_t                          state_q;
	logic [hlnc_pkg::CLR_W-1:0]      clr_q;
	logic                            open_q, too_long_q;
	logic [hlnc_pkg::LEN_W-1:0]      len_q;
	logic [31:0]                     hash_q, key_mount_q, handle_q;
	logic [63:0]                     key_parent_q;
	logic [1:0]                      kind_q;
	logic [hlnc_pkg::BUCKET_BITS-1:0] bucket_q;
	logic [PW-1:0]                   p_q, rhead_q, rtail_q, shead_q, first_q;
	logic [hlnc_pkg::CNT_W-1:0]      scount_q;
	logic [hlnc_pkg::LEN_W-1:0]      ci_q, ci_s1;
	logic                            cv_s1;
	hlnc_pkg::meta_t                 pmeta_q;
	logic [PW-1:0]                   pcn_q, pcp_q, prn_q, prp_q;
	hlnc_pkg::result_t               res_q;
	logic                            done_q;

	// Read data, registered.
	hlnc_pkg::meta_t meta_rd;
	logic [PW-1:0]   cn_rd, cp_rd, rn_rd, rp_rd, sn_rd, bh_rd;
	logic [7:0]      nb_rd, nbuf_rd;

	// Write ports.
	logic                              meta_we, cn_we, cp_we, rn_we, rp_we, sn_we, bh_we;
	logic [IW-1:0]                     meta_wa, cn_wa, cp_wa, rn_wa, rp_wa, sn_wa;
	logic [hlnc_pkg::BUCKET_BITS-1:0]  bh_wa;
	hlnc_pkg::meta_t                   meta_wd;
	logic [PW-1:0]                     cn_wd, cp_wd, rn_wd, rp_wd, sn_wd, bh_wd;
	logic                              nbuf_we;
	logic [hlnc_pkg::NB_W-1:0]         nbuf_wa;
	logic [hlnc_pkg::NBA_W-1:0]        nb_ra, nb_wa;

	// Name stream front end.
	logic                        accept;
	logic [31:0]                 h0, h1;
	logic [hlnc_pkg::LEN_W-1:0]  len0, len1;
	logic                        tl0, tl1, reject;
	logic [IW-1:0]               p_idx;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;
	assign p_idx  = p_q[IW-1:0];

	always_comb begin
		h0   = open_q ? hash_q : (item.mount_id ^ item.parent_inode[31:0]);
		len0 = open_q ? len_q : '0;
		tl0  = open_q ? too_long_q : 1'b0;
		h1   = h0;
		len1 = len0;
		tl1  = tl0;
		nbuf_we = 1'b0;
		if (item.byte_valid) begin
			h1 = (h0 << 5) - h0 + {24'd0, item.name_byte};
			if (len0 < hlnc_pkg::LEN_W'(hlnc_pkg::NAME_BYTES)) begin
				len1    = len0 + hlnc_pkg::LEN_W'(1);
				nbuf_we = accept;
			end else begin
				tl1 = 1'b1;
			end
		end
		nbuf_wa = len0[hlnc_pkg::NB_W-1:0];
		reject = (len1 == '0) || tl1 || (item.kind == hlnc_pkg::KIND_BAD)
			|| ((item.kind != hlnc_pkg::KIND_INVAL) && !item.cacheable)
			|| ((item.kind == hlnc_pkg::KIND_INSERT) && (item.object_handle == 32'd0));
	end

	// Address of the name store byte for the current entry and byte count.
	assign nb_ra = hlnc_pkg::NBA_W'(p_idx) * hlnc_pkg::NBA_W'(hlnc_pkg::NAME_BYTES)
		+ hlnc_pkg::NBA_W'(ci_q);
	assign nb_wa = hlnc_pkg::NBA_W'(p_idx) * hlnc_pkg::NBA_W'(hlnc_pkg::NAME_BYTES)
		+ hlnc_pkg::NBA_W'(ci_s1);

	// Write port control for the link and entry memories.
	always_comb begin
		meta_we = 1'b0; meta_wa = p_idx; meta_wd = pmeta_q;
		cn_we = 1'b0; cn_wa = p_idx; cn_wd = hlnc_pkg::NONE;
		cp_we = 1'b0; cp_wa = p_idx; cp_wd = hlnc_pkg::NONE;
		rn_we = 1'b0; rn_wa = p_idx; rn_wd = hlnc_pkg::NONE;
		rp_we = 1'b0; rp_wa = p_idx; rp_wd = hlnc_pkg::NONE;
		sn_we = 1'b0; sn_wa = p_idx; sn_wd = hlnc_pkg::NONE;
		bh_we = 1'b0; bh_wa = bucket_q; bh_wd = hlnc_pkg::NONE;
		case (state_q)
			S_CLR: begin
				if (32'(clr_q) < hlnc_pkg::ENTRIES) begin
					meta_we = 1'b1; cn_we = 1'b1; cp_we = 1'b1;
					rn_we = 1'b1; rp_we = 1'b1; sn_we = 1'b1;
				end
				meta_wa = clr_q[IW-1:0];
				meta_wd = '0;
				cn_wa = clr_q[IW-1:0];
				cp_wa = clr_q[IW-1:0];
				rn_wa = clr_q[IW-1:0];
				rp_wa = clr_q[IW-1:0];
				sn_wa = clr_q[IW-1:0];
				sn_wd = PW'(clr_q[IW-1:0]) + PW'(1);
				bh_we = (32'(clr_q) < hlnc_pkg::BUCKETS);
				bh_wa = clr_q[hlnc_pkg::BUCKET_BITS-1:0];
			end
			S_TU, S_DROP, S_VICT_UNL: begin
				// Recency unlink.
				if (!hlnc_pkg::is_none(prp_q)) begin
					rn_we = 1'b1; rn_wa = prp_q[IW-1:0]; rn_wd = prn_q;
				end
				if (!hlnc_pkg::is_none(prn_q)) begin
					rp_we = 1'b1; rp_wa = prn_q[IW-1:0]; rp_wd = prp_q;
				end
				// Chain unlink, not for a touch.
				if (state_q != S_TU) begin
					if (!hlnc_pkg::is_none(pcp_q)) begin
						cn_we = 1'b1; cn_wa = pcp_q[IW-1:0]; cn_wd = pcn_q;
					end else begin
						bh_we = 1'b1; bh_wa = pmeta_q.bucket; bh_wd = pcn_q;
					end
					if (!hlnc_pkg::is_none(pcn_q)) begin
						cp_we = 1'b1; cp_wa = pcn_q[IW-1:0]; cp_wd = pcp_q;
					end
				end
				// Freed entry goes back on the spare list.
				if (state_q == S_DROP) begin
					meta_we = 1'b1;
					meta_wd = pmeta_q;
					meta_wd.valid = 1'b0;
					sn_we = 1'b1;
					sn_wd = shead_q;
				end
			end
			S_F1: begin
				rn_we = 1'b1; rn_wd = rhead_q;
				rp_we = 1'b1;
			end
			S_F2: begin
				if (!hlnc_pkg::is_none(rhead_q)) begin
					rp_we = 1'b1; rp_wa = rhead_q[IW-1:0]; rp_wd = p_q;
				end
			end
			S_FILL: begin
				meta_we = 1'b1;
				meta_wd.valid  = 1'b1;
				meta_wd.mount  = key_mount_q;
				meta_wd.parent = key_parent_q;
				meta_wd.len    = len_q;
				meta_wd.obj    = handle_q;
				meta_wd.bucket = bucket_q;
			end
			S_LINK_WT: begin
				cn_we = 1'b1; cn_wd = bh_rd;
				cp_we = 1'b1;
				bh_we = 1'b1; bh_wd = p_q;
			end
			S_LINK2: begin
				if (!hlnc_pkg::is_none(first_q)) begin
					cp_we = 1'b1; cp_wa = first_q[IW-1:0]; cp_wd = p_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Memory ports.
	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[meta_wa] <= meta_wd;
		if (cn_we) cn_mem[cn_wa] <= cn_wd;
		if (cp_we) cp_mem[cp_wa] <= cp_wd;
		if (rn_we) rn_mem[rn_wa] <= rn_wd;
		if (rp_we) rp_mem[rp_wa] <= rp_wd;
		if (sn_we) sn_mem[sn_wa] <= sn_wd;
		if (bh_we) bh_mem[bh_wa] <= bh_wd;
		if (cv_s1) nb_mem[nb_wa] <= nbuf_rd;
		if (nbuf_we) nbuf_mem[nbuf_wa] <= item.name_byte;
		meta_rd <= meta_mem[p_idx];
		cn_rd   <= cn_mem[p_idx];
		cp_rd   <= cp_mem[p_idx];
		rn_rd   <= rn_mem[p_idx];
		rp_rd   <= rp_mem[p_idx];
		sn_rd   <= sn_mem[shead_q[IW-1:0]];
		bh_rd   <= bh_mem[bucket_q];
		nb_rd   <= nb_mem[nb_ra];
		nbuf_rd <= nbuf_mem[ci_q[hlnc_pkg::NB_W-1:0]];
	end

	// Name copy pipeline: the buffer byte read in one cycle is written the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s1 <= 1'b0;
			ci_s1 <= '0;
		end else begin
			cv_s1 <= (state_q == S_COPY) && (ci_q != len_q);
			ci_s1 <= ci_q;
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			open_q       <= 1'b0;
			too_long_q   <= 1'b0;
			len_q        <= '0;
			hash_q       <= '0;
			key_mount_q  <= '0;
			key_parent_q <= '0;
			handle_q     <= '0;
			kind_q       <= '0;
			bucket_q     <= '0;
			p_q          <= hlnc_pkg::NONE;
			rhead_q      <= hlnc_pkg::NONE;
			rtail_q      <= hlnc_pkg::NONE;
			shead_q      <= '0;
			scount_q     <= hlnc_pkg::CNT_W'(hlnc_pkg::ENTRIES);
			first_q      <= hlnc_pkg::NONE;
			ci_q         <= '0;
			pmeta_q      <= '0;
			pcn_q        <= hlnc_pkg::NONE;
			pcp_q        <= hlnc_pkg::NONE;
			prn_q        <= hlnc_pkg::NONE;
			prp_q        <= hlnc_pkg::NONE;
			res_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + hlnc_pkg::CLR_W'(1);
					if (clr_q == hlnc_pkg::CLR_W'(hlnc_pkg::CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (!open_q) begin
							key_mount_q  <= item.mount_id;
							key_parent_q <= item.parent_inode;
						end
						hash_q     <= h1;
						len_q      <= len1;
						too_long_q <= tl1;
						open_q     <= !item.name_last;
						kind_q     <= item.kind;
						handle_q   <= item.object_handle;
						bucket_q   <= h1[hlnc_pkg::BUCKET_BITS-1:0];
						if (item.name_last) begin
							if (reject) begin
								res_q  <= '{status: hlnc_pkg::ST_REJECTED, default: '0};
								done_q <= 1'b1;
							end else begin
								state_q <= S_HEAD;
							end
						end
					end
				end
				S_HEAD: state_q <= S_HEAD_WT;
				S_HEAD_WT: begin
					p_q     <= bh_rd;
					state_q <= S_ENT_RD;
				end
				S_ENT_RD: begin
					state_q <= hlnc_pkg::is_none(p_q) ? S_MISS : S_ENT_WT;
				end
				// Key compare on the entry record.
				S_ENT_WT: begin
					pmeta_q <= meta_rd;
					pcn_q   <= cn_rd;
					pcp_q   <= cp_rd;
					prn_q   <= rn_rd;
					prp_q   <= rp_rd;
					ci_q    <= '0;
					if (meta_rd.valid && (meta_rd.mount == key_mount_q)
							&& (meta_rd.parent == key_parent_q) && (meta_rd.len == len_q)) begin
						state_q <= S_BYTE_RD;
					end else begin
						p_q     <= cn_rd;
						state_q <= S_ENT_RD;
					end
				end
				S_BYTE_RD: state_q <= S_BYTE_CK;
				// Name compare, one byte per pass.
				S_BYTE_CK: begin
					if (nb_rd != nbuf_rd) begin
						p_q     <= pcn_q;
						state_q <= S_ENT_RD;
					end else if (ci_q + hlnc_pkg::LEN_W'(1) == len_q) begin
						state_q <= S_FOUND;
					end else begin
						ci_q    <= ci_q + hlnc_pkg::LEN_W'(1);
						state_q <= S_BYTE_RD;
					end
				end
				S_FOUND: begin
					case (kind_q)
						hlnc_pkg::KIND_LOOKUP: begin
							res_q <= '{status: hlnc_pkg::ST_HIT, ref_take: 1'b1,
								ref_handle: pmeta_q.obj, default: '0};
							state_q <= (rhead_q == p_q) ? S_DONE : S_TU;
						end
						hlnc_pkg::KIND_INSERT: begin
							res_q <= '{status: hlnc_pkg::ST_PRESENT, default: '0};
							state_q <= (rhead_q == p_q) ? S_DONE : S_TU;
						end
						default: begin
							res_q <= '{status: hlnc_pkg::ST_INVALIDATED, release_valid: 1'b1,
								release_handle: pmeta_q.obj, default: '0};
							state_q <= S_DROP;
						end
					endcase
				end
				S_MISS: begin
					if (kind_q == hlnc_pkg::KIND_INSERT) begin
						if ((scount_q != '0) && !hlnc_pkg::is_none(shead_q)) begin
							state_q <= S_SPARE;
						end else if (!hlnc_pkg::is_none(rtail_q)) begin
							p_q     <= rtail_q;
							state_q <= S_VICT_RD;
						end else begin
							res_q   <= '{status: hlnc_pkg::ST_REJECTED, default: '0};
							state_q <= S_DONE;
						end
					end else begin
						res_q   <= '{status: hlnc_pkg::ST_MISS, default: '0};
						state_q <= S_DONE;
					end
				end
				// Recency unlink for a touch, drop or eviction; head and tail follow.
				S_TU, S_DROP, S_VICT_UNL: begin
					if (hlnc_pkg::is_none(prp_q)) rhead_q <= prn_q;
					if (hlnc_pkg::is_none(prn_q)) rtail_q <= prp_q;
					if (state_q == S_DROP) begin
						shead_q  <= p_q;
						scount_q <= scount_q + hlnc_pkg::CNT_W'(1);
					end
					case (state_q)
						S_TU:    state_q <= S_F1;
						S_DROP:  state_q <= S_DONE;
						default: state_q <= S_FILL;
					endcase
				end
				S_F1: state_q <= S_F2;
				S_F2: begin
					if (hlnc_pkg::is_none(rhead_q)) rtail_q <= p_q;
					rhead_q <= p_q;
					state_q <= S_DONE;
				end
				S_SPARE: state_q <= S_SPARE_WT;
				S_SPARE_WT: begin
					p_q      <= shead_q;
					shead_q  <= sn_rd;
					scount_q <= scount_q - hlnc_pkg::CNT_W'(1);
					res_q    <= '{status: hlnc_pkg::ST_INSERTED, ref_take: 1'b1,
						ref_handle: handle_q, default: '0};
					state_q  <= S_FILL;
				end
				S_VICT_RD: state_q <= S_VICT_WT;
				// Evict the recency tail.
				S_VICT_WT: begin
					pmeta_q <= meta_rd;
					pcn_q   <= cn_rd;
					pcp_q   <= cp_rd;
					prn_q   <= rn_rd;
					prp_q   <= rp_rd;
					res_q   <= '{status: hlnc_pkg::ST_INSERTED, ref_take: 1'b1,
						ref_handle: handle_q, release_valid: 1'b1,
						release_handle: meta_rd.obj};
					state_q <= S_VICT_UNL;
				end
				S_FILL: begin
					ci_q    <= '0;
					state_q <= S_COPY;
				end
				S_COPY: begin
					if (ci_q == len_q) begin
						state_q <= S_LINK_RD;
					end else begin
						ci_q <= ci_q + hlnc_pkg::LEN_W'(1);
					end
				end
				S_LINK_RD: state_q <= S_LINK_WT;
				S_LINK_WT: begin
					first_q <= bh_rd;
					state_q <= S_LINK2;
				end
				S_LINK2: state_q <= S_F1;
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
